>>> rtl/core/silence_run_detector_unit_defines.svh
// ---------------------------------------------------------------------------
// Silence run detector assertion macros
// Concurrent checks that compile away when SYNTHESIS is defined.
// ---------------------------------------------------------------------------
`ifndef SILENCE_RUN_DETECTOR_UNIT_DEFINES_SVH
`define SILENCE_RUN_DETECTOR_UNIT_DEFINES_SVH

`ifndef SYNTHESIS
// Same-cycle implication: when cond holds, prop holds at the same edge.
`define SRD_ASSERT_IMPLY(name, clock, reset, cond, prop) \
  name: assert property (@(posedge clock) disable iff (reset) (cond) |-> (prop)) \
    else $error("silence run detector: same-cycle check failed");
// Next-cycle implication: when cond holds, prop holds at the following edge.
`define SRD_ASSERT_NEXT(name, clock, reset, cond, prop) \
  name: assert property (@(posedge clock) disable iff (reset) (cond) |=> (prop)) \
    else $error("silence run detector: next-cycle check failed");
`else
`define SRD_ASSERT_IMPLY(name, clock, reset, cond, prop)
`define SRD_ASSERT_NEXT(name, clock, reset, cond, prop)
`endif

`endif

>>> rtl/core/srd_pkg.sv
// ---------------------------------------------------------------------------
// Silence run detector package
// Shared widths, register indexes and the types passed between the stages.
// ---------------------------------------------------------------------------
package srd_pkg;

  // Datapath widths.
  localparam int LANES       = 4;
  localparam int SAMPLE_BITS = 24;
  localparam int FRAME_BITS  = 32;
  localparam int OUT_BITS    = 32;
  localparam int LEN_BITS    = FRAME_BITS + 1;

  // Register widths.
  localparam int THRESH_BITS = 24;
  localparam int MIN_BITS    = 20;
  localparam int MASK_BITS   = 4;
  localparam int START_BITS  = 32;
  localparam int DATA_BITS   = 32;
  localparam int INDEX_BITS  = 3;

  // Classification queue between front and back.
  localparam int QUEUE_DEPTH = 2;
  localparam int QPTR_BITS   = $clog2(QUEUE_DEPTH);
  localparam int QCNT_BITS   = $clog2(QUEUE_DEPTH + 1);

  // Register indexes on the write port.
  typedef enum logic [INDEX_BITS-1:0] {
    REG_THRESHOLD    = 3'd0,
    REG_MIN_RUN      = 3'd1,
    REG_EDGES_ONLY   = 3'd2,
    REG_CHANNEL_MASK = 3'd3,
    REG_RANGE_START  = 3'd4
  } reg_index_t;

  // Configuration register set.
  typedef struct packed {
    logic [THRESH_BITS-1:0] silence_threshold;
    logic [MIN_BITS-1:0]    min_run_frames;
    logic                   edges_only;
    logic [MASK_BITS-1:0]   channel_mask;
    logic [START_BITS-1:0]  range_start;
  } cfg_t;

  // One classified frame as stored in the queue.
  typedef struct packed {
    logic silent;
    logic final_frame;
  } frame_class_t;

  // Run tracker status seen by the top level.
  typedef struct packed {
    logic in_silence;
    logic offset_zero;
  } back_status_t;

  // Absolute value of a two's complement sample; the most negative code
  // maps onto its unsigned magnitude.
  function automatic logic [SAMPLE_BITS-1:0] magnitude(input logic [SAMPLE_BITS-1:0] raw);
    logic [SAMPLE_BITS-1:0] neg;
    neg = ~raw + SAMPLE_BITS'(1);
    return raw[SAMPLE_BITS-1] ? neg : raw;
  endfunction

endpackage

>>> rtl/core/srd_stream_ifs.sv
// ---------------------------------------------------------------------------
// Silence run detector stream interfaces
// Valid/ready channels for audio frames in and silent runs out.
// ---------------------------------------------------------------------------

// Audio frame channel.
interface srd_frame_if;
  logic                                 valid;
  logic                                 ready;
  logic signed [srd_pkg::SAMPLE_BITS-1:0] sample_a;
  logic signed [srd_pkg::SAMPLE_BITS-1:0] sample_b;
  logic signed [srd_pkg::SAMPLE_BITS-1:0] sample_c;
  logic signed [srd_pkg::SAMPLE_BITS-1:0] sample_d;
  logic                                 final_frame;

  modport source(output valid, sample_a, sample_b, sample_c, sample_d, final_frame,
                 input ready);
  modport sink(input valid, sample_a, sample_b, sample_c, sample_d, final_frame,
               output ready);
endinterface

// Silent run report channel.
interface srd_run_if;
  logic                          valid;
  logic                          ready;
  logic [srd_pkg::OUT_BITS-1:0]  run_first_frame;
  logic [srd_pkg::OUT_BITS-1:0]  run_frames;
  logic                          run_at_range_end;

  modport source(output valid, run_first_frame, run_frames, run_at_range_end,
                 input ready);
  modport sink(input valid, run_first_frame, run_frames, run_at_range_end,
               output ready);
endinterface

>>> rtl/core/srd_front.sv
// ---------------------------------------------------------------------------
// Silence run detector front end
// Accepts frames, takes the peak magnitude over enabled lanes and classifies
// each frame as silent or loud.
// ---------------------------------------------------------------------------
module srd_front (
  srd_frame_if.sink                          frames,
  input  logic [srd_pkg::MASK_BITS-1:0]      channel_mask,
  input  logic [srd_pkg::THRESH_BITS-1:0]    silence_threshold,
  input  logic                               queue_full,
  output logic                               push,
  output srd_pkg::frame_class_t              push_class
);

  logic [srd_pkg::SAMPLE_BITS-1:0] lane_raw [srd_pkg::LANES];
  logic [srd_pkg::SAMPLE_BITS-1:0] level;

  // Gather the sample lanes.
  assign lane_raw[0] = frames.sample_a;
  assign lane_raw[1] = frames.sample_b;
  assign lane_raw[2] = frames.sample_c;
  assign lane_raw[3] = frames.sample_d;

  // Peak magnitude over the enabled lanes; an empty mask gives zero.
  always_comb begin
    logic [srd_pkg::SAMPLE_BITS-1:0] mag;
    level = '0;
    for (int i = 0; i < srd_pkg::LANES; i++) begin
      mag = srd_pkg::magnitude(lane_raw[i]);
      if (channel_mask[i] && (mag > level)) begin
        level = mag;
      end
    end
  end

  // A request is taken whenever the queue has room.
  assign frames.ready           = !queue_full;
  assign push                   = frames.valid && !queue_full;
  assign push_class.silent      = (level <= silence_threshold);
  assign push_class.final_frame = frames.final_frame;

endmodule

>>> rtl/core/srd_queue.sv
// ---------------------------------------------------------------------------
// Silence run detector classification queue
// Two-entry FIFO that decouples the front end from the run tracker.
// ---------------------------------------------------------------------------
module srd_queue (
  input  logic                    clk,
  input  logic                    rst,
  input  logic                    push,
  input  srd_pkg::frame_class_t   push_class,
  output logic                    full,
  input  logic                    pop,
  output logic                    head_valid,
  output srd_pkg::frame_class_t   head_class
);

  srd_pkg::frame_class_t           entries [srd_pkg::QUEUE_DEPTH];
  logic [srd_pkg::QPTR_BITS-1:0]   wr_ptr;
  logic [srd_pkg::QPTR_BITS-1:0]   rd_ptr;
  logic [srd_pkg::QCNT_BITS-1:0]   count;

  // Storage has no reset; occupancy is tracked by the count.
  always_ff @(posedge clk) begin
    if (push) begin
      entries[wr_ptr] <= push_class;
    end
  end

  // Pointers and occupancy.
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == srd_pkg::QPTR_BITS'(srd_pkg::QUEUE_DEPTH - 1)) ?
                  '0 : wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == srd_pkg::QPTR_BITS'(srd_pkg::QUEUE_DEPTH - 1)) ?
                  '0 : rd_ptr + 1'b1;
      end
      if (push && !pop) begin
        count <= count + 1'b1;
      end else if (pop && !push) begin
        count <= count - 1'b1;
      end
    end
  end

  assign full       = (count == srd_pkg::QCNT_BITS'(srd_pkg::QUEUE_DEPTH));
  assign head_valid = (count != '0);
  assign head_class = entries[rd_ptr];

endmodule

>>> rtl/core/srd_back.sv
// ---------------------------------------------------------------------------
// Silence run detector back end
// Tracks silent runs over the classified frames and registers each run that
// passes the length and edge filters for the output channel.
// ---------------------------------------------------------------------------
module srd_back (
  input  logic                    clk,
  input  logic                    rst,
  input  srd_pkg::cfg_t           cfg,
  input  logic                    head_valid,
  input  srd_pkg::frame_class_t   head_class,
  output logic                    pop,
  output srd_pkg::back_status_t   status,
  srd_run_if.source               runs
);

  logic [srd_pkg::FRAME_BITS-1:0] frame_offset;
  logic [srd_pkg::FRAME_BITS-1:0] frame_offset_next;
  logic                           in_silence;
  logic                           in_silence_next;
  logic [srd_pkg::FRAME_BITS-1:0] silence_begin;
  logic [srd_pkg::FRAME_BITS-1:0] silence_begin_next;

  logic                           in_eff;
  logic [srd_pkg::FRAME_BITS-1:0] begin_eff;
  logic                           close_at_end;
  logic                           close_run;
  logic [srd_pkg::LEN_BITS-1:0]   run_end;
  logic [srd_pkg::LEN_BITS-1:0]   run_len;
  logic [srd_pkg::MIN_BITS-1:0]   need;
  logic                           long_enough;
  logic                           edge_ok;
  logic                           emit;

  // Take the next frame when the output register is free or being drained.
  assign pop = head_valid && (!runs.valid || runs.ready);

  // Open a run on the first silent frame; a loud frame or the final frame closes it.
  always_comb begin
    if (head_class.silent && !in_silence) begin
      in_eff    = 1'b1;
      begin_eff = frame_offset;
    end else begin
      in_eff    = head_class.silent && in_silence;
      begin_eff = silence_begin;
    end
  end

  // Run closure and its filters.
  assign close_at_end = head_class.final_frame && in_eff;
  assign close_run    = close_at_end || (!head_class.silent && in_silence);
  assign run_end      = close_at_end ? ({1'b0, frame_offset} + srd_pkg::LEN_BITS'(1))
                                     : {1'b0, frame_offset};
  assign run_len      = run_end - {1'b0, begin_eff};
  assign need         = (cfg.min_run_frames == '0) ? srd_pkg::MIN_BITS'(1)
                                                   : cfg.min_run_frames;
  assign long_enough  = (run_len >= srd_pkg::LEN_BITS'(need));
  assign edge_ok      = !cfg.edges_only || (begin_eff == '0) || close_at_end;
  assign emit         = close_run && long_enough && edge_ok;

  // Next tracker state; the final frame starts a fresh range.
  always_comb begin
    if (head_class.final_frame) begin
      frame_offset_next  = '0;
      in_silence_next    = 1'b0;
      silence_begin_next = '0;
    end else begin
      frame_offset_next  = (frame_offset == '1) ? frame_offset : frame_offset + 1'b1;
      in_silence_next    = in_eff;
      silence_begin_next = begin_eff;
    end
  end

  // Tracker state registers.
  always_ff @(posedge clk) begin
    if (rst) begin
      frame_offset  <= '0;
      in_silence    <= 1'b0;
      silence_begin <= '0;
    end else if (pop) begin
      frame_offset  <= frame_offset_next;
      in_silence    <= in_silence_next;
      silence_begin <= silence_begin_next;
    end
  end

  // Output valid.
  always_ff @(posedge clk) begin
    if (rst) begin
      runs.valid <= 1'b0;
    end else if (pop) begin
      runs.valid <= emit;
    end else if (runs.ready) begin
      runs.valid <= 1'b0;
    end
  end

  // Output payload.
  always_ff @(posedge clk) begin
    if (pop && emit) begin
      runs.run_first_frame  <= cfg.range_start + srd_pkg::OUT_BITS'(begin_eff);
      runs.run_frames       <= srd_pkg::OUT_BITS'(run_len);
      runs.run_at_range_end <= close_at_end;
    end
  end

  assign status.in_silence  = in_silence;
  assign status.offset_zero = (frame_offset == '0);

endmodule

>>> rtl/core/silence_run_detector_unit.sv
// ---------------------------------------------------------------------------
// Silence run detector
// Finds runs of silent audio frames and reports their start and length.
// ---------------------------------------------------------------------------
// Usage:
//   frames carries one audio frame per request: four signed samples and a
//   last-frame mark. runs carries one report per silent run that passes the
//   minimum length and, when edges-only is set, touches a range edge. The user
//   must write registers through write_en, reg_index and write_data while the
//   block is idle (not enforced). Indexes past the register list are ignored.
// Timing:
//   The front end classifies a frame in the cycle it is taken and pushes it
//   into a two-entry queue. The run tracker pops one entry per cycle unless a
//   held report stalls it; a report is registered at the edge that pops its
//   closing frame. Throughput is one frame per cycle while runs is not stalled.
// Reset and stalls:
//   Reset clears the registers to their defaults and empties the queue and
//   the run state. While runs is stalled, frames keeps being taken until the
//   queue fills; frames whose result is held back wait in the queue.
// ---------------------------------------------------------------------------
`include "silence_run_detector_unit_defines.svh"

module silence_run_detector_unit (
  input  logic                           clk,
  input  logic                           rst,
  srd_frame_if.sink                      frames,
  srd_run_if.source                      runs,
  input  logic                           write_en,
  input  logic [srd_pkg::INDEX_BITS-1:0] reg_index,
  input  logic [srd_pkg::DATA_BITS-1:0]  write_data
);

  srd_pkg::cfg_t          cfg;
  logic                   push;
  srd_pkg::frame_class_t  push_class;
  logic                   queue_full;
  logic                   pop;
  logic                   head_valid;
  srd_pkg::frame_class_t  head_class;
  srd_pkg::back_status_t  status;
  logic                   final_pop;
  logic                   tracker_fresh;

  // Configuration registers.
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.silence_threshold <= '0;
      cfg.min_run_frames    <= srd_pkg::MIN_BITS'(1);
      cfg.edges_only        <= 1'b0;
      cfg.channel_mask      <= srd_pkg::MASK_BITS'(1);
      cfg.range_start       <= '0;
    end else if (write_en) begin
      unique case (srd_pkg::reg_index_t'(reg_index))
        srd_pkg::REG_THRESHOLD: begin
          cfg.silence_threshold <= write_data[srd_pkg::THRESH_BITS-1:0];
        end
        srd_pkg::REG_MIN_RUN: begin
          cfg.min_run_frames <= write_data[srd_pkg::MIN_BITS-1:0];
        end
        srd_pkg::REG_EDGES_ONLY: begin
          cfg.edges_only <= write_data[0];
        end
        srd_pkg::REG_CHANNEL_MASK: begin
          cfg.channel_mask <= write_data[srd_pkg::MASK_BITS-1:0];
        end
        srd_pkg::REG_RANGE_START: begin
          cfg.range_start <= write_data[srd_pkg::START_BITS-1:0];
        end
        default: begin
        end
      endcase
    end
  end

  // Front end: level detection and classification.
  srd_front u_front (
    .frames            (frames),
    .channel_mask      (cfg.channel_mask),
    .silence_threshold (cfg.silence_threshold),
    .queue_full        (queue_full),
    .push              (push),
    .push_class        (push_class)
  );

  // Queue between classification and run tracking.
  srd_queue u_queue (
    .clk        (clk),
    .rst        (rst),
    .push       (push),
    .push_class (push_class),
    .full       (queue_full),
    .pop        (pop),
    .head_valid (head_valid),
    .head_class (head_class)
  );

  // Back end: run tracking and report register.
  srd_back u_back (
    .clk        (clk),
    .rst        (rst),
    .cfg        (cfg),
    .head_valid (head_valid),
    .head_class (head_class),
    .pop        (pop),
    .status     (status),
    .runs       (runs)
  );

  // Terms used by the checks below.
  assign final_pop     = pop && head_class.final_frame;
  assign tracker_fresh = !status.in_silence && status.offset_zero;

  // A final frame always leaves the tracker at the start of a new range.
  `SRD_ASSERT_NEXT(a_final_clears_run, clk, rst, final_pop, tracker_fresh)
  // A new report only appears after the tracker took a frame.
  `SRD_ASSERT_IMPLY(a_report_from_pop, clk, rst, $rose(runs.valid), $past(pop))

endmodule
